>>> design/assert_macros.svh
// Assertion helpers used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("%m: check failed");

// Property checked outside of reset.
`define ASSERT_NO_RST(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: check failed");

`endif

>>> design/baa_pkg.sv
`timescale 1ns / 1ps

package baa_pkg;

   // Result width and quotient bits of the ratio divider
   localparam int ANGLE_BITS = 8;
   localparam int QUO_BITS   = 8;

   // Binary angle constants
   localparam logic [ANGLE_BITS-1:0] ANG_ZERO    = 8'h00;
   localparam logic [ANGLE_BITS-1:0] ANG_EIGHTH  = 8'h20;
   localparam logic [ANGLE_BITS-1:0] ANG_QUARTER = 8'h40;
   localparam logic [ANGLE_BITS-1:0] ANG_HALF    = 8'h80;

   // Arctangent table, octant part: ROM[r] = floor(atan(r/256)*128/pi), 0..31
   localparam int ROM_BITS   = 5;
   localparam int STEP_COUNT = 31;

   // Smallest ratio at which the table value reaches k, k = 1..31
   localparam logic [QUO_BITS-1:0] ATAN_STEPS [STEP_COUNT] = '{
      8'd7,   8'd13,  8'd19,  8'd26,  8'd32,  8'd38,  8'd45,  8'd51,
      8'd58,  8'd65,  8'd71,  8'd78,  8'd85,  8'd92,  8'd99,  8'd107,
      8'd114, 8'd122, 8'd129, 8'd137, 8'd146, 8'd154, 8'd163, 8'd172,
      8'd181, 8'd190, 8'd200, 8'd211, 8'd221, 8'd233, 8'd244
   };

   // Constant 256 x 5 table, expressed through its step points
   function automatic logic [ROM_BITS-1:0] atan_rom(input logic [QUO_BITS-1:0] ratio);
      logic [ROM_BITS-1:0] val;
      val = '0;
      for (int k = 0; k < STEP_COUNT; k++) begin
         if (ratio >= ATAN_STEPS[k]) begin
            val = val + ROM_BITS'(1);
         end
      end
      return val;
   endfunction

endpackage

>>> design/baa_req_if.sv
`timescale 1ns / 1ps

// Vector transaction channel
interface baa_req_if #(
   parameter int COORD_BITS = 16
) ();
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] vec_x;
   logic signed [COORD_BITS-1:0] vec_y;

   modport source (output valid, output vec_x, output vec_y, input ready);
   modport sink   (input valid, input vec_x, input vec_y, output ready);
endinterface

>>> design/baa_rsp_if.sv
`timescale 1ns / 1ps

// Angle transaction channel
interface baa_rsp_if ();
   logic       valid;
   logic       ready;
   logic [7:0] angle;

   modport source (output valid, output angle, input ready);
   modport sink   (input valid, input angle, output ready);
endinterface

>>> design/binary_angle_atan2.sv
`timescale 1ns / 1ps
// Each accepted vector moves through the stages below in order; its angle leaves from the mirror stage.
// Throughput: one transaction per clock; prep stage, 8 divider stages (one quotient
// bit each), table stage and mirror stage. Empty stages fill up while the output stalls.
// Reset: synchronous, active high; clears all stage valid bits, data is not reset.
module binary_angle_atan2 #(
   parameter int COORD_BITS = 16
) (
   input logic         clock,
   input logic         reset,
   baa_req_if.sink     req_ch,
   baa_rsp_if.source   rsp_ch
);
   import baa_pkg::*;

   localparam int W        = COORD_BITS;
   localparam int ROM_STG  = QUO_BITS + 1;
   localparam int LAST_STG = QUO_BITS + 2;
   localparam int NSTG     = QUO_BITS + 3;

   typedef struct packed {
      logic [W-1:0]          mag_hi;   // divisor: larger magnitude
      logic [W-1:0]          rem;
      logic [QUO_BITS-1:0]   quo;
      logic [ANGLE_BITS-1:0] oct;
      logic                  zero;
      logic                  xneg;
      logic                  yneg;     // negated y below zero
      logic                  ygt;      // |y| > |x|
      logic                  eq;
   } stage_type;

   stage_type        pipe_ff [NSTG];
   stage_type        pipe_in [NSTG];
   logic [NSTG-1:0]  vld_ff;
   logic [NSTG-1:0]  adv;

   // Per-stage advance: a stage moves when it is empty or the next one moves
   assign adv[NSTG-1] = !vld_ff[NSTG-1] || rsp_ch.ready;
   for (genvar i = 0; i < NSTG - 1; i++) begin : g_adv
      assign adv[i] = !vld_ff[i] || adv[i+1];
   end

   assign req_ch.ready = adv[0];
   assign rsp_ch.valid = vld_ff[NSTG-1];
   assign rsp_ch.angle = pipe_ff[NSTG-1].oct;

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) begin
            vld_ff[0] <= req_ch.valid;
         end
         for (int i = 1; i < NSTG; i++) begin
            if (adv[i]) begin
               vld_ff[i] <= vld_ff[i-1];
            end
         end
      end
   end

   // Stage data
   always_ff @(posedge clock) begin
      for (int i = 0; i < NSTG; i++) begin
         if (adv[i]) begin
            pipe_ff[i] <= pipe_in[i];
         end
      end
   end

   // Prep: negate y, magnitudes, compare and order the operands
   always_comb begin
      logic signed [W:0] sx;
      logic signed [W:0] sy;
      logic signed [W:0] ax_w;
      logic signed [W:0] ay_w;
      logic [W-1:0]      ax;
      logic [W-1:0]      ay;
      logic              lt;
      logic              gt;
      sx   = {req_ch.vec_x[W-1], req_ch.vec_x};
      sy   = {req_ch.vec_y[W-1], req_ch.vec_y};
      ax_w = sx[W] ? -sx : sx;
      ay_w = sy[W] ? -sy : sy;
      ax   = ax_w[W-1:0];
      ay   = ay_w[W-1:0];
      lt   = ay < ax;
      gt   = ay > ax;
      pipe_in[0]        = '0;
      pipe_in[0].mag_hi = lt ? ax : ay;
      pipe_in[0].rem    = lt ? ay : ax;
      pipe_in[0].zero   = (req_ch.vec_x == '0) && (req_ch.vec_y == '0);
      pipe_in[0].xneg   = req_ch.vec_x[W-1];
      pipe_in[0].yneg   = !req_ch.vec_y[W-1] && (req_ch.vec_y != '0);
      pipe_in[0].ygt    = gt;
      pipe_in[0].eq     = !lt && !gt;
   end

   // Restoring divider, one quotient bit per stage
   for (genvar k = 1; k <= QUO_BITS; k++) begin : g_div
      always_comb begin
         logic [W+1:0] rem2;
         logic [W+1:0] diff;
         rem2       = {1'b0, pipe_ff[k-1].rem, 1'b0};
         diff       = rem2 - {2'b00, pipe_ff[k-1].mag_hi};
         pipe_in[k] = pipe_ff[k-1];
         if (!diff[W+1]) begin
            pipe_in[k].rem = diff[W-1:0];
            pipe_in[k].quo = {pipe_ff[k-1].quo[QUO_BITS-2:0], 1'b1};
         end else begin
            pipe_in[k].rem = rem2[W-1:0];
            pipe_in[k].quo = {pipe_ff[k-1].quo[QUO_BITS-2:0], 1'b0};
         end
      end
   end

   // Table lookup and octant angle
   always_comb begin
      logic [ANGLE_BITS-1:0] rv;
      rv               = ANGLE_BITS'(atan_rom(pipe_ff[ROM_STG-1].quo));
      pipe_in[ROM_STG] = pipe_ff[ROM_STG-1];
      if (pipe_ff[ROM_STG-1].eq) begin
         pipe_in[ROM_STG].oct = ANG_EIGHTH;
      end else if (pipe_ff[ROM_STG-1].ygt) begin
         pipe_in[ROM_STG].oct = ANG_QUARTER - rv;
      end else begin
         pipe_in[ROM_STG].oct = rv;
      end
   end

   // Quadrant mirroring, zero vector override
   always_comb begin
      logic [ANGLE_BITS-1:0] v;
      v = pipe_ff[LAST_STG-1].oct;
      if (pipe_ff[LAST_STG-1].xneg) begin
         v = ANG_HALF - v;
      end
      if (pipe_ff[LAST_STG-1].yneg) begin
         v = ANG_ZERO - v;
      end
      if (pipe_ff[LAST_STG-1].zero) begin
         v = ANG_ZERO;
      end
      pipe_in[LAST_STG]     = pipe_ff[LAST_STG-1];
      pipe_in[LAST_STG].oct = v;
   end

endmodule

>>> design/baa_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Port-level checks for the angle pipeline
module baa_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [baa_pkg::ANGLE_BITS-1:0] rsp_angle
);
   import baa_pkg::*;

   // Reset empties the pipeline
   `ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid)

   // A free output slot lets every stage move, so input is always taken
   `ASSERT_ALWAYS(a_ready_when_free, clock, (!rsp_valid || rsp_ready) |-> req_ready)

   // A stalled response transaction holds
   `ASSERT_NO_RST(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_angle)))

   // Input is refused only while a response is waiting
   `ASSERT_NO_RST(a_stall_cause, clock, reset, (req_valid && !req_ready) |-> (rsp_valid && !rsp_ready))

endmodule

bind binary_angle_atan2 baa_checker u_baa_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_angle (rsp_ch.angle)
);

>>> sim/binary_angle_atan2_tb.sv
`timescale 1ns / 1ps

module binary_angle_atan2_tb;
   import baa_pkg::*;

   localparam int CB          = 16;
   localparam int RANDOM_VECS = 1550;
   localparam int LONG_HOLD   = 150;
   localparam int HOLD_AT     = 300;
   localparam int DRAIN_WAIT  = 24;
   localparam int CYCLE_LIMIT = 200000;
   localparam int FULL_TURN   = 256;
   localparam int RATIO_SHIFT = 8;
   localparam int MAX_POS     = 32767;
   localparam int MIN_NEG     = -32768;

   // Ratio at which the octant angle steps up by one, for steps 1..31
   localparam int OCTANT_STEPS [31] = '{
      7, 13, 19, 26, 32, 38, 45, 51, 58, 65, 71, 78, 85, 92, 99, 107,
      114, 122, 129, 137, 146, 154, 163, 172, 181, 190, 200, 211, 221, 233, 244
   };

   typedef struct packed {
      logic signed [CB-1:0] x;
      logic signed [CB-1:0] y;
   } vec_t;

   typedef struct packed {
      vec_t       v;
      logic [7:0] angle;
   } angle_exp_t;

   logic clock;
   logic reset;

   baa_req_if #(.COORD_BITS(CB)) req_if ();
   baa_rsp_if                    rsp_if ();

   binary_angle_atan2 #(.COORD_BITS(CB)) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if.sink),
      .rsp_ch (rsp_if.source)
   );

   vec_t       pending_vecs [$];
   angle_exp_t angle_q [$];

   int   vec_count;
   int   angle_count;
   int   err_count;
   int   cycle_count;
   int   req_gap;
   int   rsp_wait;
   int   hold_left;
   bit   hold_done;
   logic req_took;
   logic rsp_took;

   // Expected binary angle of a screen-space vector
   function automatic logic [7:0] predict_angle(input vec_t v);
      int sx, sy, ax, ay, ratio, oct;
      sx = int'(v.x);
      sy = -int'(v.y);
      ax = (sx < 0) ? -sx : sx;
      ay = (sy < 0) ? -sy : sy;
      if (sx == 0 && sy == 0) begin
         return ANG_ZERO;
      end
      oct = 0;
      if (ay != ax) begin
         ratio = (ay < ax) ? (ay << RATIO_SHIFT) / ax : (ax << RATIO_SHIFT) / ay;
         for (int k = 0; k < 31; k++) begin
            if (ratio >= OCTANT_STEPS[k]) begin
               oct++;
            end
         end
         if (ay > ax) begin
            oct = int'(ANG_QUARTER) - oct;
         end
      end else begin
         oct = int'(ANG_EIGHTH);
      end
      // mirror into the right quadrant
      if (sx < 0) begin
         oct = int'(ANG_HALF) - oct;
      end
      if (sy < 0) begin
         oct = FULL_TURN - oct;
      end
      return oct[7:0];
   endfunction

   task automatic add_vec(input int x, input int y);
      vec_t v;
      v.x = x[CB-1:0];
      v.y = y[CB-1:0];
      pending_vecs.push_back(v);
   endtask

   task automatic report_mismatch(input string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      err_count++;
   endtask

   // Random vector, weighted toward table steps, diagonals and extremes
   function automatic vec_t random_vec();
      vec_t v;
      int   a, b, tmp;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            tmp = $urandom;
            v.x = tmp[CB-1:0];
            v.y = tmp[2*CB-1:CB];
            return v;
         end
         4, 5: begin
            // land on or next to a step of the table
            a = $urandom_range(1, MAX_POS);
            b = (OCTANT_STEPS[$urandom_range(0, 30)] * a + 255) >> RATIO_SHIFT;
            b = b - int'($urandom_range(0, 1));
         end
         6: begin
            a = $urandom_range(1, MAX_POS - 2);
            b = a + int'($urandom_range(0, 2));
         end
         7: begin
            a = $urandom_range(0, 20);
            b = $urandom_range(0, 20);
         end
         8: begin
            a = $urandom_range(0, 1) ? MAX_POS : $urandom_range(0, 1);
            b = $urandom_range(0, 1) ? 0 : MAX_POS;
         end
         default: begin
            a = $urandom_range(0, MAX_POS);
            b = $urandom_range(0, 1) ? MAX_POS : 0;
         end
      endcase
      if ($urandom_range(0, 1)) begin
         tmp = a;
         a = b;
         b = tmp;
      end
      if ($urandom_range(0, 1)) a = -a;
      if ($urandom_range(0, 1)) b = -b;
      // the most negative value is only reachable by a sign flip here
      if (a == -MAX_POS && $urandom_range(0, 3) == 0) a = MIN_NEG;
      if (b == -MAX_POS && $urandom_range(0, 3) == 0) b = MIN_NEG;
      v.x = a[CB-1:0];
      v.y = b[CB-1:0];
      return v;
   endfunction

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Known values on every input from time zero
   initial begin
      reset         = 1'b1;
      req_if.valid  = 1'b0;
      req_if.vec_x  = '0;
      req_if.vec_y  = '0;
      rsp_if.ready  = 1'b0;
   end

   // Cycle counter and timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d angles outstanding",
                  cycle_count, angle_q.size());
         $display("[binary_angle_atan2] ERROR");
         $finish;
      end
   end

   // Sender: one vector per transaction, random gap after each
   always @(negedge clock) begin : drive_req
      vec_t v;
      if (reset) begin
         req_if.valid <= 1'b0;
         req_gap      <= 0;
      end else if (!req_if.valid || req_took) begin
         if (req_gap != 0) begin
            req_if.valid <= 1'b0;
            req_gap      <= req_gap - 1;
         end else if (pending_vecs.size() != 0) begin
            v = pending_vecs.pop_front();
            req_if.vec_x <= v.x;
            req_if.vec_y <= v.y;
            req_if.valid <= 1'b1;
            // every fourth stretch runs back to back
            req_gap <= ((vec_count / 128) % 4 == 3) ? 0 : $urandom_range(0, 3);
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Receiver: random stall per angle, plus one long hold to back up the pipe
   always @(negedge clock) begin : drive_rsp
      int w;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_wait     <= 0;
         hold_left    <= 0;
         hold_done    <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_if.ready <= 1'b0;
         hold_left    <= hold_left - 1;
      end else if (!hold_done && angle_count >= HOLD_AT) begin
         rsp_if.ready <= 1'b0;
         hold_left    <= LONG_HOLD;
         hold_done    <= 1'b1;
      end else if (rsp_took) begin
         if ((angle_count / 96) % 4 == 1) begin
            rsp_wait     <= 0;
            rsp_if.ready <= 1'b1;
         end else begin
            w = $urandom_range(0, 3);
            if (w == 0) begin
               rsp_wait     <= 0;
               rsp_if.ready <= 1'b1;
            end else begin
               rsp_wait     <= w - 1;
               rsp_if.ready <= 1'b0;
            end
         end
      end else if (rsp_wait != 0) begin
         rsp_wait     <= rsp_wait - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // Monitor: predict on each accepted vector, check each accepted angle
   always @(posedge clock) begin : monitor
      angle_exp_t e;
      vec_t       v;
      if (reset) begin
         req_took <= 1'b0;
         rsp_took <= 1'b0;
      end else begin
         req_took <= req_if.valid && req_if.ready;
         rsp_took <= rsp_if.valid && rsp_if.ready;
         if (req_if.valid && req_if.ready) begin
            v.x = req_if.vec_x;
            v.y = req_if.vec_y;
            e.v = v;
            e.angle = predict_angle(v);
            angle_q.push_back(e);
            vec_count++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            angle_count++;
            if (angle_q.size() == 0) begin
               report_mismatch($sformatf("angle %02h with no vector outstanding",
                                         rsp_if.angle));
            end else begin
               e = angle_q.pop_front();
               if (rsp_if.angle !== e.angle) begin
                  report_mismatch($sformatf("x=%0d y=%0d angle %02h, expected %02h",
                                            e.v.x, e.v.y, rsp_if.angle, e.angle));
               end
            end
         end
      end
   end

   // Stimulus and end of test
   initial begin
      vec_count   = 0;
      angle_count = 0;
      err_count   = 0;
      cycle_count = 0;

      // zero vector, axes and the most negative components
      add_vec(0, 0);
      add_vec(MAX_POS, 0);
      add_vec(MIN_NEG, 0);
      add_vec(0, MIN_NEG);
      add_vec(0, MAX_POS);
      add_vec(1, 0);
      add_vec(0, -1);
      // diagonals in all four quadrants, including full scale
      add_vec(1, 1);
      add_vec(-1, 1);
      add_vec(1, -1);
      add_vec(-1, -1);
      add_vec(MIN_NEG, MIN_NEG);
      add_vec(MAX_POS, -MAX_POS);
      add_vec(MIN_NEG, MAX_POS);
      // table steps at both ends, in several octants
      add_vec(256, 7);
      add_vec(256, 6);
      add_vec(-256, 244);
      add_vec(256, -243);
      add_vec(7, -256);
      add_vec(-244, -256);
      add_vec(MAX_POS, MIN_NEG);
      add_vec(MIN_NEG, -1);
      add_vec(3, MIN_NEG);

      for (int i = 0; i < RANDOM_VECS; i++) begin
         pending_vecs.push_back(random_vec());
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_vecs.size() != 0 || req_if.valid || angle_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("%0d vectors sent, %0d angles checked, with random gaps on both channels",
               vec_count, angle_count);
      $display("output held off for %0d cycles once to back the pipeline up", LONG_HOLD);
      if (err_count == 0) begin
         $display("[binary_angle_atan2] OK");
      end else begin
         $display("%0d mismatches", err_count);
         $display("[binary_angle_atan2] ERROR");
      end
      $finish;
   end

endmodule
